// ===== rtl/vrt_pkg.sv =====
// package for the voxel ray traversal block
// shared widths, constants, sequencer state type and unit request structs
`default_nettype none
package vrt_pkg;

    // fixed-point widths
    localparam int LEN_W  = 32;          // direction length, Q16.16
    localparam int DEN_W  = 20;          // range times direction magnitude
    localparam int NUM_W  = 49;          // dividend width of the shared divider
    localparam int DVS_W  = 36;          // divisor width of the shared divider
    localparam int PROD_W = 49;          // multiplier product, 17 x 32
    localparam int VOX_W  = 17;          // voxel coordinate
    localparam int CNT_W  = 6;           // voxel count up to three times range

    localparam logic [31:0] T_INF = 32'hFFFF_FFFF;
    localparam logic [31:0] T_ONE = 32'h0001_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_AX_DEN,
        S_AX_TDGO,
        S_AX_TDW,
        S_AX_DIST,
        S_AX_TMGO,
        S_AX_TMW,
        S_AX_NEXT,
        S_WALK
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DVS_W-1:0] dvs;
    } t_div_req;

    typedef struct packed {
        logic        start;
        logic [63:0] rad;
    } t_sqrt_req;

endpackage
`default_nettype wire

// ===== rtl/voxel_ray_traversal.sv =====
// top level of the voxel ray traversal block: sequencer, shared multiplier, walk
// depends on vrt_pkg, vrt_sqrt and vrt_div
`default_nettype none
// Takes one ray per input beat and emits the voxels it crosses as output beats,
// tlast on the final one. Setup runs on one 17 x 32 multiplier, a 32-step square
// root and a 49-step divider shared by the six per-axis divisions; setup time is
// dominated by the divider (an axis with zero direction, or a zero range, skips its
// divisions). The walk then emits one voxel per cycle while the output side takes
// them, at least one and up to three times the range. The input is not ready until
// the last voxel has been handed to the output register. max_range is written over
// the config channel, always ready.
module voxel_ray_traversal #(
    parameter int RANGE_MAX = 15
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config channel: max_range
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [3:0]   i_cfg_data,
    // ray in
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // start_x, start_y, start_z, dir_x, dir_y, dir_z
    input  wire logic [143:0] i_s_axis_tdata,
    // voxel out
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // voxel_x, voxel_y, voxel_z, zero pad
    output logic [55:0]       o_m_axis_tdata,
    output logic              o_m_axis_tlast
);
    import vrt_pkg::*;

    localparam logic [5:0] RMAX = 6'(RANGE_MAX);

    t_state r_state, n_state;

    logic [3:0]        r_max_range;
    logic [3:0]        r_range;
    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_n;
    logic [1:0]        r_ax;
    logic [15:0]       r_frac [3];
    logic [15:0]       r_mag  [3];
    logic              r_neg  [3];
    logic              r_stp  [3];
    logic [VOX_W-1:0]  r_vox  [3];
    logic [31:0]       r_tm   [3];
    logic [31:0]       r_td   [3];
    logic [31:0]       r_sum;
    logic [LEN_W-1:0]  r_len;
    logic [DEN_W-1:0]  r_den;
    logic [PROD_W-1:0] r_prod;

    logic              r_out_valid;
    logic [VOX_W-1:0]  r_out_vox [3];
    logic              r_out_last;

    logic              n_in_beat;
    logic              n_out_free;
    logic [16:0]       n_mul_a;
    logic [31:0]       n_mul_b;
    logic [16:0]       n_dist;
    logic              n_skip;
    t_div_req          n_div_req;
    t_sqrt_req         n_sqrt_req;
    logic              w_div_done;
    logic [31:0]       w_div_quot;
    logic              w_sqrt_done;
    logic [31:0]       w_sqrt_root;

    logic [1:0]        n_a;
    logic [32:0]       n_adv;
    logic [31:0]       n_tm_new;
    logic              n_exit;
    logic              n_last;
    logic [31:0]       n_t0, n_t1, n_t2;

    assign n_in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign n_out_free = !r_out_valid || i_m_axis_tready;
    assign n_dist     = r_neg[r_ax] ? {1'b0, r_frac[r_ax]} : (17'h10000 - {1'b0, r_frac[r_ax]});
    assign n_skip     = (r_range == 4'd0) || (r_mag[r_ax] == 16'd0);

    // shared multiplier operand selection
    always_comb begin
        n_mul_a = {1'b0, r_mag[r_ax]};
        n_mul_b = {16'd0, r_mag[r_ax]};
        case (r_state)
            S_AX_DEN:  n_mul_a = {13'd0, r_range};
            S_AX_DIST: begin
                n_mul_a = n_dist;
                n_mul_b = r_len;
            end
            default: ;
        endcase
    end

    // next crossing and exit test for the walk
    always_comb begin
        if (r_tm[0] < r_tm[1]) begin
            n_a = (r_tm[0] < r_tm[2]) ? 2'd0 : 2'd2;
        end else begin
            n_a = (r_tm[1] < r_tm[2]) ? 2'd1 : 2'd2;
        end
        n_adv    = {1'b0, r_tm[n_a]} + {1'b0, r_td[n_a]};
        n_tm_new = n_adv[32] ? T_INF : n_adv[31:0];
        n_t0     = (n_a == 2'd0) ? n_tm_new : r_tm[0];
        n_t1     = (n_a == 2'd1) ? n_tm_new : r_tm[1];
        n_t2     = (n_a == 2'd2) ? n_tm_new : r_tm[2];
        n_exit   = (n_t0 > T_ONE) && (n_t1 > T_ONE) && (n_t2 > T_ONE);
        n_last   = (r_n >= r_cap) || n_exit;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (n_in_beat) n_state = S_SQ_MUL;
            S_SQ_MUL:    n_state = S_SQ_ACC;
            S_SQ_ACC:    n_state = (r_ax == 2'd2) ? S_SQRT_GO : S_SQ_MUL;
            S_SQRT_GO:   n_state = S_SQRT_WAIT;
            S_SQRT_WAIT: if (w_sqrt_done) n_state = S_AX_DEN;
            S_AX_DEN:    n_state = n_skip ? S_AX_NEXT : S_AX_TDGO;
            S_AX_TDGO:   n_state = S_AX_TDW;
            S_AX_TDW:    if (w_div_done) n_state = S_AX_DIST;
            S_AX_DIST:   n_state = S_AX_TMGO;
            S_AX_TMGO:   n_state = S_AX_TMW;
            S_AX_TMW:    if (w_div_done) n_state = S_AX_NEXT;
            S_AX_NEXT:   n_state = (r_ax == 2'd2) ? S_WALK : S_AX_DEN;
            S_WALK:      if (n_out_free && n_last) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // unit requests and handshake outputs
    always_comb begin
        n_sqrt_req.start = (r_state == S_SQRT_GO);
        n_sqrt_req.rad   = {r_sum, 32'd0};
        n_div_req.start  = (r_state == S_AX_TDGO) || (r_state == S_AX_TMGO);
        if (r_state == S_AX_TDGO) begin
            n_div_req.num = NUM_W'(r_len) + NUM_W'(r_prod[DEN_W-1:1]);
            n_div_req.dvs = DVS_W'(r_prod[DEN_W-1:0]);
        end else begin
            n_div_req.num = r_prod[NUM_W-1:0] + NUM_W'({r_den, 15'd0});
            n_div_req.dvs = {r_den, 16'd0};
        end
        o_s_axis_tready = (r_state == S_IDLE);
        o_cfg_ready     = 1'b1;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_range <= 4'd7;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_max_range <= i_cfg_data;
            end
            if (r_state == S_WALK && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(n_mul_a) * PROD_W'(n_mul_b);
        case (r_state)
            S_IDLE: begin
                if (n_in_beat) begin
                    for (int i = 0; i < 3; i++) begin
                        r_frac[i] <= i_s_axis_tdata[32*i +: 16];
                        r_vox[i]  <= {i_s_axis_tdata[32*i+31], i_s_axis_tdata[32*i+16 +: 16]};
                        r_neg[i]  <= i_s_axis_tdata[96+16*i+15];
                        r_mag[i]  <= i_s_axis_tdata[96+16*i+15]
                                     ? (16'd0 - i_s_axis_tdata[96+16*i +: 16])
                                     : i_s_axis_tdata[96+16*i +: 16];
                    end
                    if ({2'b00, r_max_range} > RMAX) begin
                        r_range <= RMAX[3:0];
                        r_cap   <= CNT_W'({RMAX[3:0], 1'b0}) + CNT_W'(RMAX[3:0]);
                    end else begin
                        r_range <= r_max_range;
                        r_cap   <= CNT_W'({r_max_range, 1'b0}) + CNT_W'(r_max_range);
                    end
                    r_sum <= '0;
                    r_ax  <= 2'd0;
                    r_n   <= CNT_W'(1);
                end
            end
            S_SQ_ACC: begin
                r_sum <= r_sum + r_prod[31:0];
                r_ax  <= r_ax + 2'd1;
            end
            S_SQRT_WAIT: begin
                r_len <= w_sqrt_root;
                r_ax  <= 2'd0;
            end
            S_AX_DEN: begin
                if (n_skip) begin
                    r_stp[r_ax] <= 1'b0;
                    r_tm[r_ax]  <= T_INF;
                    r_td[r_ax]  <= T_INF;
                end else begin
                    r_stp[r_ax] <= 1'b1;
                end
            end
            S_AX_TDGO: r_den <= r_prod[DEN_W-1:0];
            S_AX_TDW:  if (w_div_done) r_td[r_ax] <= w_div_quot;
            S_AX_TMW:  if (w_div_done) r_tm[r_ax] <= w_div_quot;
            S_AX_NEXT: r_ax <= r_ax + 2'd1;
            S_WALK: begin
                if (n_out_free) begin
                    r_out_vox  <= r_vox;
                    r_out_last <= n_last;
                    if (!n_last) begin
                        if (r_stp[n_a]) begin
                            r_vox[n_a] <= r_neg[n_a] ? (r_vox[n_a] - 17'd1)
                                                     : (r_vox[n_a] + 17'd1);
                        end
                        r_tm[n_a] <= n_tm_new;
                        r_n       <= r_n + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    vrt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_sqrt_req),
        .o_done  (w_sqrt_done),
        .o_root  (w_sqrt_root)
    );

    vrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_vox[2], r_out_vox[1], r_out_vox[0]};
    assign o_m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/vrt_sqrt.sv =====
// iterative integer square root, two radicand bits per cycle
// depends on vrt_pkg
`default_nettype none
module vrt_sqrt (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vrt_pkg::t_sqrt_req i_req,
    output logic                   o_done,
    output logic [31:0]            o_root
);
    import vrt_pkg::*;

    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [33:0] n_shift;
    logic [33:0] n_trial;
    logic        n_bit;

    // one result bit per cycle
    always_comb begin
        n_shift = {r_rem[31:0], r_rad[63:62]};
        n_trial = {r_root, 2'b01};
        n_bit   = (n_shift >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rad  <= i_req.rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 6'd32;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[61:0], 2'b00};
                r_rem  <= n_bit ? (n_shift - n_trial) : n_shift;
                r_root <= {r_root[30:0], n_bit};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ===== rtl/vrt_div.sv =====
// iterative restoring divider, one quotient bit per cycle, saturating to 32 bits
// depends on vrt_pkg
`default_nettype none
module vrt_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire vrt_pkg::t_div_req i_req,
    output logic                  o_done,
    output logic [31:0]           o_quot
);
    import vrt_pkg::*;

    logic [NUM_W-1:0] r_num;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   r_rem;
    logic [NUM_W-1:0] r_q;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   n_trial;
    logic             n_bit;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        n_trial = {r_rem[DVS_W-1:0], r_num[NUM_W-1]};
        n_bit   = (n_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= i_req.num;
                r_dvs  <= i_req.dvs;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= 6'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_rem  <= n_bit ? (n_trial - {1'b0, r_dvs}) : n_trial;
                r_q    <= {r_q[NUM_W-2:0], n_bit};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // saturate to infinite time
    assign o_done = r_done;
    assign o_quot = (|r_q[NUM_W-1:32]) ? T_INF : r_q[31:0];

endmodule
`default_nettype wire
